[src/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg: shared types, constants and microprogram of the line editor
// control words, byte codes, step numbers and the microcode rom
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int BUFFER_SIZE_DEF = 32;

	localparam int UPC_W = 4;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// step numbers of the microprogram
	localparam logic [UPC_W-1:0] ST_FETCH   = 4'd0;
	localparam logic [UPC_W-1:0] ST_DECODE  = 4'd1;
	localparam logic [UPC_W-1:0] ST_PRINT   = 4'd2;
	localparam logic [UPC_W-1:0] ST_ERASE0  = 4'd3;
	localparam logic [UPC_W-1:0] ST_ERASE1  = 4'd4;
	localparam logic [UPC_W-1:0] ST_ERASE2  = 4'd5;
	localparam logic [UPC_W-1:0] ST_PR_LF   = 4'd6;
	localparam logic [UPC_W-1:0] ST_PR_CR   = 4'd7;
	localparam logic [UPC_W-1:0] ST_PR_GT0  = 4'd8;
	localparam logic [UPC_W-1:0] ST_PR_GT1  = 4'd9;
	localparam logic [UPC_W-1:0] ST_PR_SP   = 4'd10;
	localparam logic [UPC_W-1:0] ST_LN_LF   = 4'd11;
	localparam logic [UPC_W-1:0] ST_LN_CR   = 4'd12;
	localparam logic [UPC_W-1:0] ST_RD_WAIT = 4'd13;
	localparam logic [UPC_W-1:0] ST_RD_EMIT = 4'd14;
	localparam logic [UPC_W-1:0] ST_LN_FIN  = 4'd15;

	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_RX    = 2'd1,
		SRC_MEM   = 2'd2
	} src_t;

	typedef enum logic [1:0] {
		LS_NO       = 2'd0,
		LS_YES      = 2'd1,
		LS_LINE_END = 2'd2
	} last_sel_t;

	typedef enum logic [2:0] {
		J_NEXT = 3'd0,
		J_GOTO = 3'd1,
		J_WAIT = 3'd2,
		J_DISP = 3'd3,
		J_LOOP = 3'd4
	} jump_t;

	typedef enum logic [2:0] {
		CLS_NONE      = 3'd0,
		CLS_PRINT     = 3'd1,
		CLS_ERASE     = 3'd2,
		CLS_EOL_EMPTY = 3'd3,
		CLS_EOL_LINE  = 3'd4,
		CLS_DONE      = 3'd5
	} cls_t;

	typedef struct packed {
		logic             emit;
		src_t             src;
		logic             okind;
		logic [7:0]       cbyte;
		last_sel_t        lsel;
		logic             store;
		logic             dec;
		logic             rptr_clr;
		logic             rptr_inc;
		logic             line_done;
		logic             mode_clr;
		jump_t            jc;
		logic [UPC_W-1:0] tgt;
	} ucw_t;

	// sequencer to datapath
	typedef struct packed {
		ucw_t uw;
		logic fire;
		logic take;
	} dp_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		cls_t cls;
		logic line_end;
		logic out_free;
	} dp_stat_t;

	function automatic ucw_t ucw_emit(input logic [7:0] b, input last_sel_t ls);
		ucw_t w;
		w = '0;
		w.emit  = 1'b1;
		w.src   = SRC_CONST;
		w.cbyte = b;
		w.lsel  = ls;
		w.jc    = J_NEXT;
		return w;
	endfunction

	function automatic ucw_t ucode(input logic [UPC_W-1:0] step);
		ucw_t w;
		w = '0;
		w.src  = SRC_CONST;
		w.lsel = LS_NO;
		w.jc   = J_NEXT;
		case (step)
			ST_FETCH: begin
				w.jc = J_WAIT;
			end
			ST_DECODE: begin
				w.jc = J_DISP;
			end
			ST_PRINT: begin
				w.emit  = 1'b1;
				w.src   = SRC_RX;
				w.lsel  = LS_YES;
				w.store = 1'b1;
				w.jc    = J_GOTO;
				w.tgt   = ST_FETCH;
			end
			ST_ERASE0: w = ucw_emit(CH_BS, LS_NO);
			ST_ERASE1: w = ucw_emit(CH_SP, LS_NO);
			ST_ERASE2: begin
				w     = ucw_emit(CH_BS, LS_YES);
				w.dec = 1'b1;
				w.jc  = J_GOTO;
				w.tgt = ST_FETCH;
			end
			ST_PR_LF:  w = ucw_emit(CH_LF, LS_NO);
			ST_PR_CR:  w = ucw_emit(CH_CR, LS_NO);
			ST_PR_GT0: w = ucw_emit(CH_GT, LS_NO);
			ST_PR_GT1: w = ucw_emit(CH_GT, LS_NO);
			ST_PR_SP: begin
				w          = ucw_emit(CH_SP, LS_YES);
				w.mode_clr = 1'b1;
				w.jc       = J_GOTO;
				w.tgt      = ST_FETCH;
			end
			ST_LN_LF: begin
				w          = ucw_emit(CH_LF, LS_NO);
				w.rptr_clr = 1'b1;
			end
			ST_LN_CR:  w = ucw_emit(CH_CR, LS_NO);
			// read data of the store settles here
			ST_RD_WAIT: begin
				w.jc = J_NEXT;
			end
			ST_RD_EMIT: begin
				w.emit     = 1'b1;
				w.src      = SRC_MEM;
				w.okind    = 1'b1;
				w.lsel     = LS_LINE_END;
				w.rptr_inc = 1'b1;
				w.jc       = J_LOOP;
				w.tgt      = ST_RD_WAIT;
			end
			ST_LN_FIN: begin
				w.line_done = 1'b1;
				w.rptr_clr  = 1'b1;
				w.jc        = J_GOTO;
				w.tgt       = ST_FETCH;
			end
			default: begin
				w.jc  = J_GOTO;
				w.tgt = ST_FETCH;
			end
		endcase
		return w;
	endfunction

	function automatic logic [UPC_W-1:0] disp_target(input cls_t c);
		logic [UPC_W-1:0] t;
		case (c)
			CLS_PRINT:     t = ST_PRINT;
			CLS_ERASE:     t = ST_ERASE0;
			CLS_EOL_EMPTY: t = ST_PR_LF;
			CLS_DONE:      t = ST_PR_LF;
			CLS_EOL_LINE:  t = ST_LN_LF;
			default:       t = ST_FETCH;
		endcase
		return t;
	endfunction

endpackage

[src/sle_useq.sv]
// ----------------------------------------------------------------------------
// sle_useq: microcode sequencer
// step counter, control rom and conditional jump logic
// ----------------------------------------------------------------------------
module sle_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sle_pkg::dp_stat_t  stat,
	output sle_pkg::dp_ctrl_t  ctrl
);
	import sle_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	ucw_t             uw;
	logic             fire;
	logic             take;

	assign uw       = ucode(upc_q);
	assign in_ready = (upc_q == ST_FETCH);
	assign take     = in_ready && in_valid;
	// an emitting step waits for room in the output register
	assign fire     = !uw.emit || stat.out_free;

	assign ctrl.uw   = uw;
	assign ctrl.fire = fire;
	assign ctrl.take = take;

	always_comb begin
		upc_nxt = upc_q;
		if (fire) begin
			case (uw.jc)
				J_NEXT: upc_nxt = upc_q + 1'b1;
				J_GOTO: upc_nxt = uw.tgt;
				J_WAIT: upc_nxt = take ? upc_q + 1'b1 : upc_q;
				J_DISP: upc_nxt = disp_target(stat.cls);
				J_LOOP: upc_nxt = stat.line_end ? upc_q + 1'b1 : uw.tgt;
				default: upc_nxt = ST_FETCH;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_FETCH;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

[src/sle_dpath.sv]
// ----------------------------------------------------------------------------
// sle_dpath: line editor datapath
// input latch, mode and count registers, line store and output register
// ----------------------------------------------------------------------------
module sle_dpath #(
	parameter int BUFFER_SIZE = sle_pkg::BUFFER_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               kind,
	input  logic [7:0]         rx_byte,
	input  sle_pkg::dp_ctrl_t  ctrl,
	output sle_pkg::dp_stat_t  stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_kind,
	output logic [7:0]         out_byte,
	output logic               last
);
	import sle_pkg::*;

	localparam int LINE_CAP = BUFFER_SIZE - 1;
	localparam int CW       = $clog2(BUFFER_SIZE);
	localparam int AW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

	logic            kind_q;
	logic [7:0]      byte_q;
	logic            mode_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rptr_q;
	logic [7:0]      mem_q [LINE_CAP];
	logic [7:0]      rd_data_q;
	logic            out_valid_q;
	logic            out_kind_q;
	logic [7:0]      out_byte_q;
	logic            last_q;

	logic            room;
	logic            cnt_nz;
	logic            line_end;
	logic            do_emit;
	logic [7:0]      emit_byte;
	logic            emit_last;
	cls_t            cls;

	assign room     = (count_q < CW'(LINE_CAP));
	assign cnt_nz   = (count_q != '0);
	assign line_end = ((rptr_q + 1'b1) == count_q);
	assign do_emit  = ctrl.fire && ctrl.uw.emit;

	always_comb begin
		cls = CLS_NONE;
		if (mode_q) begin
			if (kind_q) begin
				cls = CLS_DONE;
			end
		end else if (!kind_q) begin
			if (byte_q == CH_CR || byte_q == CH_LF) begin
				cls = cnt_nz ? CLS_EOL_LINE : CLS_EOL_EMPTY;
			end else if (byte_q == CH_BS || byte_q == CH_DEL) begin
				cls = cnt_nz ? CLS_ERASE : CLS_NONE;
			end else if (byte_q >= CH_SP && byte_q <= CH_TILDE) begin
				cls = CLS_PRINT;
			end
		end
	end

	assign stat.cls      = cls;
	assign stat.line_end = line_end;
	assign stat.out_free = !out_valid_q || out_ready;

	always_comb begin
		case (ctrl.uw.src)
			SRC_RX:  emit_byte = byte_q;
			SRC_MEM: emit_byte = rd_data_q;
			default: emit_byte = ctrl.uw.cbyte;
		endcase
		case (ctrl.uw.lsel)
			LS_YES:      emit_last = 1'b1;
			LS_LINE_END: emit_last = line_end;
			default:     emit_last = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			kind_q <= kind;
			byte_q <= rx_byte;
		end
		if (ctrl.fire && ctrl.uw.store && room) begin
			mem_q[count_q[AW-1:0]] <= byte_q;
		end
		rd_data_q <= mem_q[rptr_q[AW-1:0]];
		if (do_emit) begin
			out_kind_q <= ctrl.uw.okind;
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			count_q     <= '0;
			rptr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.fire) begin
				if (ctrl.uw.line_done) begin
					count_q <= '0;
					mode_q  <= 1'b1;
				end else if (ctrl.uw.store && room) begin
					count_q <= count_q + 1'b1;
				end else if (ctrl.uw.dec) begin
					count_q <= count_q - 1'b1;
				end
				if (ctrl.uw.mode_clr) begin
					mode_q <= 1'b0;
				end
				if (ctrl.uw.rptr_clr) begin
					rptr_q <= '0;
				end else if (ctrl.uw.rptr_inc) begin
					rptr_q <= rptr_q + 1'b1;
				end
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

[src/serial_line_editor_with_echo_core.sv]
// ----------------------------------------------------------------------------
// serial_line_editor_with_echo_core: terminal line editor with echo
// microcoded: a sequencer steps a control rom that drives the datapath
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------
//  input   | in  | in_valid / in_ready  | kind, rx_byte
//  output  | out | out_valid / out_ready| out_kind, out_byte, last
//
// one item at a time: a fetch step takes it and a decode step dispatches it,
// then one emitting step per echo byte; a completed line needs a wait step
// and an emit step per stored character since each line store read is
// registered, plus one closing step.
// reset clears mode, count and sequencer; the line store needs no clearing.
// a stalled output holds the sequencer on its emitting step.
//
module serial_line_editor_with_echo_core #(
	parameter int BUFFER_SIZE = sle_pkg::BUFFER_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic       last
);
	import sle_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	sle_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	sle_dpath #(
		.BUFFER_SIZE (BUFFER_SIZE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

[tb/sv/line_editor_checker.sv]
// ----------------------------------------------------------------------------
// line_editor_checker: scoreboard for the serial line editor
// follows every accepted input transfer, predicts the echo and command line
// bytes it causes and compares them in order with the output transfers
// ----------------------------------------------------------------------------
package line_editor_tb_pkg;

	// input item kinds
	localparam logic KIND_RX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// output item kinds
	localparam logic OUT_ECHO = 1'b0;
	localparam logic OUT_LINE = 1'b1;

endpackage

module line_editor_checker #(
	parameter int BUFFER_SIZE = sle_pkg::BUFFER_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       out_kind,
	input  logic [7:0] out_byte,
	input  logic       last,
	output int         errors,
	output int         pending
);
	import sle_pkg::*;
	import line_editor_tb_pkg::*;

	localparam int LINE_CAP = BUFFER_SIZE - 1;

	typedef struct packed {
		logic       okind;
		logic [7:0] obyte;
		logic       fin;
	} echo_item_t;

	echo_item_t  expected_q[$];
	logic        waiting;
	int unsigned line_len;
	logic [7:0]  line_buf [0:LINE_CAP-1];

	task automatic push_echo(input logic ok, input logic [7:0] b);
		echo_item_t item;
		item.okind = ok;
		item.obyte = b;
		item.fin   = 1'b0;
		expected_q.push_back(item);
	endtask

	task automatic push_eol();
		push_echo(OUT_ECHO, CH_LF);
		push_echo(OUT_ECHO, CH_CR);
	endtask

	task automatic push_prompt();
		push_echo(OUT_ECHO, CH_GT);
		push_echo(OUT_ECHO, CH_GT);
		push_echo(OUT_ECHO, CH_SP);
	endtask

	task automatic predict_transfer(input logic k, input logic [7:0] b);
		int         n0;
		echo_item_t tail;
		n0 = expected_q.size();
		if (waiting) begin
			if (k == KIND_DONE) begin
				push_eol();
				push_prompt();
				waiting = 1'b0;
			end
		end else if (k == KIND_RX) begin
			if (b == CH_CR || b == CH_LF) begin
				push_eol();
				if (line_len > 0) begin
					for (int i = 0; i < line_len; i++)
						push_echo(OUT_LINE, line_buf[i]);
					line_len = 0;
					waiting  = 1'b1;
				end else begin
					push_prompt();
				end
			end else if (b == CH_BS || b == CH_DEL) begin
				if (line_len > 0) begin
					push_echo(OUT_ECHO, CH_BS);
					push_echo(OUT_ECHO, CH_SP);
					push_echo(OUT_ECHO, CH_BS);
					line_len--;
				end
			end else if (b >= CH_SP && b <= CH_TILDE) begin
				push_echo(OUT_ECHO, b);
				// full line: echoed but dropped
				if (line_len < LINE_CAP) begin
					line_buf[line_len] = b;
					line_len++;
				end
			end
		end
		if (expected_q.size() > n0) begin
			tail = expected_q.pop_back();
			tail.fin = 1'b1;
			expected_q.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		echo_item_t want;
		if (!arst_n) begin
			expected_q.delete();
			waiting  = 1'b0;
			line_len = 0;
			errors   = 0;
			pending  = 0;
		end else begin
			if (in_valid && in_ready)
				predict_transfer(kind, rx_byte);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected output transfer: out_kind %0d, out_byte %h, last %0d",
						out_kind, out_byte, last);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (out_kind !== want.okind) begin
						$error("out_kind: expected %0d, actual %0d", want.okind, out_kind);
						errors++;
					end
					if (out_byte !== want.obyte) begin
						$error("out_byte: expected %h, actual %h", want.obyte, out_byte);
						errors++;
					end
					if (last !== want.fin) begin
						$error("last: expected %0d, actual %0d", want.fin, last);
						errors++;
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for the serial line editor core
// drives directed and random received bytes and command-done events with
// random gaps on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module testbench;
	import sle_pkg::*;
	import line_editor_tb_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int ITEM_COUNT  = 330;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       kind;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic       out_kind;
	logic [7:0] out_byte;
	logic       last;

	int fail_count;
	int open_results;
	int cycles = 0;
	int sent   = 0;
	bit no_idle = 1'b0;

	serial_line_editor_with_echo_core #(
		.BUFFER_SIZE(BUFFER_SIZE_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.last     (last)
	);

	line_editor_checker #(
		.BUFFER_SIZE(BUFFER_SIZE_DEF)
	) line_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.rx_byte  (rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind (out_kind),
		.out_byte (out_byte),
		.last     (last),
		.errors   (fail_count),
		.pending  (open_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// control byte that the editor ignores
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while ((b >= CH_SP && b <= CH_TILDE) || b == CH_BS || b == CH_LF ||
			b == CH_CR || b == CH_DEL);
		return b;
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(CH_SP, CH_TILDE));
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(input logic k, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (open_results != 0)
			@(negedge clk);
	endtask

	// printable characters with occasional erases and noise, then CR or LF
	task automatic send_line(input int len, input bit clean);
		int r;
		for (int i = 0; i < len; i++) begin
			r = clean ? 99 : $urandom_range(0, 99);
			if (r < 8)
				send_item(KIND_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL);
			else if (r < 12)
				send_item(KIND_RX, noise_byte());
			else
				send_item(KIND_RX, printable());
		end
		send_item(KIND_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
	endtask

	initial begin : receiver
		int g;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
			g = pick_gap();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int  r;
		int  len;
		bit  paused;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind     = KIND_RX;
		rx_byte  = 8'h00;
		paused   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty line prompts, erase on empty line, ignored control bytes
		send_item(KIND_RX, CH_CR);
		send_item(KIND_RX, CH_LF);
		send_item(KIND_RX, CH_BS);
		send_item(KIND_RX, CH_DEL);
		send_item(KIND_RX, 8'h00);
		send_item(KIND_RX, 8'hFF);
		send_item(KIND_RX, 8'h1F);
		send_item(KIND_RX, 8'h80);
		// done while editing is ignored
		send_item(KIND_DONE, 8'hA5);
		send_item(KIND_RX, CH_SP);
		send_item(KIND_RX, CH_TILDE);
		send_item(KIND_RX, 8'h41);
		send_item(KIND_RX, CH_BS);
		send_item(KIND_RX, CH_DEL);
		send_item(KIND_RX, 8'h7B);
		send_item(KIND_RX, CH_CR);
		// bytes while waiting are ignored
		send_item(KIND_RX, 8'h61);
		send_item(KIND_RX, CH_LF);
		send_item(KIND_RX, CH_BS);
		send_item(KIND_DONE, 8'h00);
		send_item(KIND_DONE, 8'hFF);
		send_item(KIND_RX, 8'h5A);
		send_item(KIND_RX, CH_LF);
		send_item(KIND_DONE, 8'h5A);

		// line full: the last printable bytes are echoed but dropped
		send_line(BUFFER_SIZE_DEF + 1, 1'b1);
		send_item(KIND_DONE, 8'($urandom));

		while (sent < ITEM_COUNT) begin
			if (!paused && sent >= 160) begin
				wait_drained();
				paused = 1'b1;
			end
			no_idle = (sent >= 210 && sent < 260);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, BUFFER_SIZE_DEF + 4)
					: $urandom_range(0, 8);
				send_line(len, 1'b0);
				repeat ($urandom_range(0, 2))
					send_item(KIND_RX, 8'($urandom));
				if ($urandom_range(0, 9) != 0)
					send_item(KIND_DONE, 8'($urandom));
			end else if (r < 90) begin
				send_item(1'($urandom_range(0, 1)), 8'($urandom));
			end else begin
				// unfinished line followed by a stray done
				repeat ($urandom_range(1, 4))
					send_item(KIND_RX, printable());
				send_item(KIND_DONE, 8'($urandom));
			end
		end

		no_idle = 1'b0;
		wait_drained();
		repeat (100) @(negedge clk);
		if (fail_count == 0 && open_results == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
